// File: design/vfs_pkg.sv
package vfs_pkg;

  // Event selector carried on the input tuser.
  localparam logic [2:0] CMD_HEALTH  = 3'd0;
  localparam logic [2:0] CMD_ARMING  = 3'd1;
  localparam logic [2:0] CMD_RC      = 3'd2;
  localparam logic [2:0] CMD_LANDED  = 3'd3;
  localparam logic [2:0] CMD_GOAL    = 3'd4;
  localparam logic [2:0] CMD_RESULT  = 3'd5;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_DISARM  = 3'd1;
  localparam logic [2:0] ACT_RETURN  = 3'd2;
  localparam logic [2:0] ACT_LAND    = 3'd3;
  localparam logic [2:0] ACT_CANCEL  = 3'd4;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_RETURN = 2'd1;
  localparam logic [1:0] MODE_LAND   = 2'd2;

  localparam logic [2:0] CAUSE_NONE    = 3'd0;
  localparam logic [2:0] CAUSE_BATTERY = 3'd1;
  localparam logic [2:0] CAUSE_RADIO   = 3'd2;
  localparam logic [2:0] CAUSE_ROTOR   = 3'd3;
  localparam logic [2:0] CAUSE_MANUAL  = 3'd4;
  localparam logic [2:0] CAUSE_MISSION = 3'd5;

  localparam logic [1:0] RES_ABORTED = 2'd2;
  localparam logic [1:0] RES_UNKNOWN = 2'd3;
  localparam logic [1:0] ERR_OTHER   = 2'd3;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  // Input payload fields, packed as on tdata (first member in the highest bits here).
  typedef struct packed {
    logic [1:0] abort_error;
    logic [1:0] result_code;
    logic       mission_kind;
    logic       rc_enable;
    logic       rc_ok;
    logic       flag_value;
    logic       velocity_ok;
    logic       position_ok;
    logic       rotor_failed;
    logic       radio_failed;
    logic       battery_failed;
  } in_fields_t;

  typedef struct packed {
    logic [2:0] cause;
    logic [1:0] mode;
    logic [2:0] action;
  } out_item_t;

endpackage

// File: design/vehicle_failsafe_supervisor_core.sv
// Vehicle failsafe supervisor core.
//
// Input channel (s_axis): one event per transfer. tuser carries the event
// selector (health, arming, rc input, landed, goal response, mission result);
// tdata carries the event fields, most of which only matter for one selector.
// Output channel (m_axis): exactly one result per input event, carrying the
// requested action, the failsafe mode after the event and the cause.
//
// The design has two register stages: an input register that captures the
// event, and a result register. The supervisor state (failsafe mode and the
// latched arming, rc and landed values) is updated in the same cycle that an
// event moves from the input register into the result register, so events are
// applied strictly in arrival order. An input transfer is captured in the input
// register and then passed to the result register that drives m_axis. Throughput
// is one event per cycle while the receiver keeps m_axis_tready high.
//
// When the receiver stalls, the result register holds its value and the
// input register can still take one more event; tready drops only once both
// stages are full. Reset clears both valid flags and all supervisor state to
// its idle values (mode none, nothing seen).
module vehicle_failsafe_supervisor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] battery_failed, [1] radio_failed, [2] rotor_failed, [3] position_ok,
  // [4] velocity_ok, [5] flag_value, [6] rc_ok, [7] rc_enable,
  // [8] mission_kind, [10:9] result_code, [12:11] abort_error, [15:13] ignored
  input  logic [15:0] s_axis_tdata,
  // [2:0] command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] action, [4:3] mode, [7:5] cause
  output logic [7:0]  m_axis_tdata
);

  localparam int unsigned FieldW = $bits(vfs_pkg::in_fields_t);

  // Input stage.
  logic                 in_valid_q;
  vfs_pkg::in_fields_t  in_fields_q;
  logic [2:0]           in_cmd_q;

  // Result stage.
  logic                 out_valid_q;
  vfs_pkg::out_item_t   out_item_q, out_item_d;

  // Supervisor state.
  logic [1:0] mode_q, mode_d;
  logic       arming_seen_q, arming_seen_d;
  logic       armed_q, armed_d;
  logic       rc_seen_q, rc_seen_d;
  logic       rc_valid_q, rc_valid_d;
  logic       rc_enabled_q, rc_enabled_d;
  logic       landed_seen_q, landed_seen_d;
  logic       landed_q, landed_d;

  logic advance;
  logic in_xfer;

  // The event leaves the input stage whenever the result register is free
  // or is being emptied in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_fields_q <= vfs_pkg::in_fields_t'(s_axis_tdata[FieldW-1:0]);
      in_cmd_q    <= s_axis_tuser;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  // Event evaluation.
  always_comb begin
    logic       landed_now;
    logic       manual;
    logic       ready;
    logic       fault;
    logic       start_land;
    logic [2:0] fault_cause;
    logic       mission_fail;
    logic [2:0] act;
    logic [2:0] why;

    mode_d        = mode_q;
    arming_seen_d = arming_seen_q;
    armed_d       = armed_q;
    rc_seen_d     = rc_seen_q;
    rc_valid_d    = rc_valid_q;
    rc_enabled_d  = rc_enabled_q;
    landed_seen_d = landed_seen_q;
    landed_d      = landed_q;
    act           = vfs_pkg::ACT_NONE;
    why           = vfs_pkg::CAUSE_NONE;

    landed_now = landed_seen_q && landed_q;
    manual     = !in_fields_q.radio_failed && rc_seen_q && rc_valid_q && rc_enabled_q;
    ready      = !manual && in_fields_q.position_ok && in_fields_q.velocity_ok;

    // Battery outranks radio, which outranks rotor. Only battery asks for land.
    fault       = in_fields_q.battery_failed || in_fields_q.radio_failed ||
                  in_fields_q.rotor_failed;
    start_land  = in_fields_q.battery_failed;
    if (in_fields_q.battery_failed) begin
      fault_cause = vfs_pkg::CAUSE_BATTERY;
    end else if (in_fields_q.radio_failed) begin
      fault_cause = vfs_pkg::CAUSE_RADIO;
    end else begin
      fault_cause = vfs_pkg::CAUSE_ROTOR;
    end

    mission_fail = 1'b0;

    case (in_cmd_q)
      vfs_pkg::CMD_HEALTH: begin
        if (arming_seen_q && armed_q) begin
          if (mode_q == vfs_pkg::MODE_NONE) begin
            if (fault && landed_now) begin
              act = vfs_pkg::ACT_DISARM;
              why = fault_cause;
            end else if (fault && ready) begin
              act    = start_land ? vfs_pkg::ACT_LAND : vfs_pkg::ACT_RETURN;
              why    = fault_cause;
              mode_d = start_land ? vfs_pkg::MODE_LAND : vfs_pkg::MODE_RETURN;
            end
          end else if (manual) begin
            act    = vfs_pkg::ACT_CANCEL;
            why    = vfs_pkg::CAUSE_MANUAL;
            mode_d = vfs_pkg::MODE_NONE;
          end else if (mode_q == vfs_pkg::MODE_RETURN &&
                       in_fields_q.battery_failed && ready) begin
            // A battery fault during a return escalates to land.
            act    = vfs_pkg::ACT_LAND;
            why    = vfs_pkg::CAUSE_BATTERY;
            mode_d = vfs_pkg::MODE_LAND;
          end
        end
      end
      vfs_pkg::CMD_ARMING: begin
        // Only a known armed-to-disarmed edge clears the mode.
        if (arming_seen_q && armed_q && !in_fields_q.flag_value) begin
          mode_d = vfs_pkg::MODE_NONE;
        end
        arming_seen_d = 1'b1;
        armed_d       = in_fields_q.flag_value;
      end
      vfs_pkg::CMD_RC: begin
        rc_seen_d    = 1'b1;
        rc_valid_d   = in_fields_q.rc_ok;
        rc_enabled_d = in_fields_q.rc_enable;
      end
      vfs_pkg::CMD_LANDED: begin
        landed_seen_d = 1'b1;
        landed_d      = in_fields_q.flag_value;
      end
      vfs_pkg::CMD_GOAL: begin
        mission_fail = !in_fields_q.flag_value;
      end
      vfs_pkg::CMD_RESULT: begin
        mission_fail = (in_fields_q.result_code == vfs_pkg::RES_UNKNOWN) ||
                       (in_fields_q.result_code == vfs_pkg::RES_ABORTED &&
                        in_fields_q.abort_error == vfs_pkg::ERR_OTHER);
      end
      default: begin
      end
    endcase

    // A failed return falls back to land; a failed land disarms.
    if (mission_fail) begin
      why = vfs_pkg::CAUSE_MISSION;
      if (in_fields_q.mission_kind) begin
        act = vfs_pkg::ACT_DISARM;
      end else begin
        act    = vfs_pkg::ACT_LAND;
        mode_d = vfs_pkg::MODE_LAND;
      end
    end

    out_item_d.action = act;
    out_item_d.mode   = mode_d;
    out_item_d.cause  = why;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= vfs_pkg::MODE_NONE;
      arming_seen_q <= 1'b0;
      armed_q       <= 1'b0;
      rc_seen_q     <= 1'b0;
      rc_valid_q    <= 1'b0;
      rc_enabled_q  <= 1'b0;
      landed_seen_q <= 1'b0;
      landed_q      <= 1'b0;
    end else if (advance) begin
      mode_q        <= mode_d;
      arming_seen_q <= arming_seen_d;
      armed_q       <= armed_d;
      rc_seen_q     <= rc_seen_d;
      rc_valid_q    <= rc_valid_d;
      rc_enabled_q  <= rc_enabled_d;
      landed_seen_q <= landed_seen_d;
      landed_q      <= landed_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q;

  // Every result that asks for an action names a cause, and only those do.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_item_q.action == vfs_pkg::ACT_NONE) ==
                     (out_item_q.cause == vfs_pkg::CAUSE_NONE)))
    else $error("action and cause disagree");

  // Starting land or return leaves the matching mode in the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.action == vfs_pkg::ACT_LAND) |->
      (out_item_q.mode == vfs_pkg::MODE_LAND))
    else $error("land started without land mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.action == vfs_pkg::ACT_RETURN) |->
      (out_item_q.mode == vfs_pkg::MODE_RETURN))
    else $error("return started without return mode");

  // The reported mode is the state the supervisor holds after the event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_item_q.mode == mode_q))
    else $error("reported mode differs from held mode");

endmodule
